FILE: rtl/stt_pkg.sv
package stt_pkg;

  localparam int OffsetBitsDef = 16;
  localparam int MaxRes = 3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SLASH, ST_LINE_CMT, ST_BLOCK, ST_BLOCK_STAR,
    ST_IDENT, ST_INT, ST_INT_DOT, ST_FRAC, ST_OP2
  } scan_state_t;

  localparam logic [5:0] K_EOF    = 6'd0;
  localparam logic [5:0] K_ERROR  = 6'd1;
  localparam logic [5:0] K_IDENT  = 6'd2;
  localparam logic [5:0] K_INT    = 6'd3;
  localparam logic [5:0] K_DOUBLE = 6'd4;
  localparam logic [5:0] K_SLASH  = 6'd25;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] start_offset;
    logic [15:0] lexeme_length;
    logic [15:0] line_number;
    logic        last;
  } token_t;

  // Up to three tokens caused by one byte.
  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
    token_t     tok2;
  } burst_t;

  function automatic logic alpha_byte(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
  endfunction

  function automatic logic digit_byte(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [5:0] lone_kind(input logic [7:0] c);
    case (c)
      8'h28: return 6'd15;
      8'h29: return 6'd16;
      8'h7b: return 6'd17;
      8'h7d: return 6'd18;
      8'h2c: return 6'd19;
      8'h3b: return 6'd20;
      8'h23: return 6'd21;
      8'h2b: return 6'd22;
      8'h2d: return 6'd23;
      8'h2a: return 6'd24;
      8'h2f: return 6'd25;
      8'h25: return 6'd26;
      8'h5e: return 6'd27;
      8'h7e: return 6'd28;
      8'h26: return 6'd30;
      8'h7c: return 6'd32;
      8'h21: return 6'd34;
      8'h3d: return 6'd36;
      8'h3c: return 6'd39;
      8'h3e: return 6'd42;
      default: return 6'd0;
    endcase
  endfunction

  function automatic logic [5:0] pair_kind(input logic [7:0] p, input logic [7:0] c);
    case (p)
      8'h26: return (c == 8'h26) ? 6'd29 : 6'd0;
      8'h7c: return (c == 8'h7c) ? 6'd31 : 6'd0;
      8'h21: return (c == 8'h3d) ? 6'd33 : 6'd0;
      8'h3d: return (c == 8'h3d) ? 6'd35 : 6'd0;
      8'h3c: return (c == 8'h3c) ? 6'd37 : ((c == 8'h3d) ? 6'd38 : 6'd0);
      8'h3e: return (c == 8'h3e) ? 6'd40 : ((c == 8'h3d) ? 6'd41 : 6'd0);
      default: return 6'd0;
    endcase
  endfunction

  // Keyword lookup over the first six bytes, first byte low.
  function automatic logic [5:0] ident_kind(input logic [47:0] w, input logic [2:0] n);
    logic [5:0] k;
    k = K_IDENT;
    case (n)
      3'd2: begin
        if (w[15:0] == 16'h6e66) k = 6'd7;
        if (w[15:0] == 16'h6669) k = 6'd9;
      end
      3'd3: begin
        if (w[23:0] == 24'h726f66) k = 6'd8;
        if (w[23:0] == 24'h6c696e) k = 6'd10;
        if (w[23:0] == 24'h726176) k = 6'd13;
      end
      3'd4: begin
        if (w[31:0] == 32'h65736c65) k = 6'd5;
        if (w[31:0] == 32'h65757274) k = 6'd12;
      end
      3'd5: begin
        if (w[39:0] == 40'h65736c6166) k = 6'd6;
        if (w[39:0] == 40'h656c696877) k = 6'd14;
      end
      3'd6: begin
        if (w == 48'h6e7275746572) k = 6'd11;
      end
      default: k = K_IDENT;
    endcase
    return k;
  endfunction

endpackage

FILE: rtl/stt_front.sv
module stt_front #(
  parameter int OFFSET_BITS = stt_pkg::OffsetBitsDef
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_ch,
  output logic            q_valid,
  input  logic            q_ready,
  output stt_pkg::burst_t q_data
);
  import stt_pkg::*;

  localparam logic [OFFSET_BITS-1:0] OMAX = '1;

  scan_state_t           st_r, st_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt, line_r, line_nxt;
  logic [OFFSET_BITS-1:0] lstart_r, lstart_nxt, lcnt_r, lcnt_nxt;
  logic [47:0]           win_r, win_nxt;
  logic [7:0]            pend_r, pend_nxt;
  logic                  ended_r, ended_nxt;

  logic                  acc;
  burst_t                b;
  token_t                t [MaxRes];
  logic [1:0]            n;

  assign in_ready = q_ready;
  assign acc      = in_valid && in_ready;

  function automatic logic [OFFSET_BITS-1:0] sadd(input logic [OFFSET_BITS-1:0] a,
                                                   input logic [1:0] d);
    logic [OFFSET_BITS:0] s;
    s = {1'b0, a} + {{(OFFSET_BITS-1){1'b0}}, d};
    return s[OFFSET_BITS] ? OMAX : s[OFFSET_BITS-1:0];
  endfunction

  function automatic logic [OFFSET_BITS-1:0] sadd2(input logic [OFFSET_BITS-1:0] a,
                                                    input logic [OFFSET_BITS-1:0] d);
    logic [OFFSET_BITS:0] s;
    s = {1'b0, a} + {1'b0, d};
    return s[OFFSET_BITS] ? OMAX : s[OFFSET_BITS-1:0];
  endfunction

  function automatic logic [15:0] fsat(input logic [OFFSET_BITS-1:0] v);
    logic [OFFSET_BITS+15:0] e;
    e = {16'd0, v};
    return (|e[OFFSET_BITS+15:16]) ? 16'hffff : e[15:0];
  endfunction

  always_comb begin
    logic        fl;
    logic [5:0]  k;
    logic [7:0]  c;
    logic [2:0]  wn;
    c          = in_ch;
    st_nxt     = st_r;
    pos_nxt    = pos_r;
    line_nxt   = line_r;
    lstart_nxt = lstart_r;
    lcnt_nxt   = lcnt_r;
    win_nxt    = win_r;
    pend_nxt   = pend_r;
    ended_nxt  = ended_r;
    n          = 2'd0;
    fl         = 1'b0;
    k          = 6'd0;
    wn         = (lcnt_r > OFFSET_BITS'(6)) ? 3'd7 : lcnt_r[2:0];
    for (int i = 0; i < MaxRes; i++) t[i] = '0;

    if (!ended_r) begin
      if (c == 8'h00) begin
        fl = 1'b1;
      end else begin
        fl = 1'b1;
        case (st_r)
          ST_IDENT: if (alpha_byte(c) || digit_byte(c)) begin
            fl = 1'b0;
            if (lcnt_r < OFFSET_BITS'(6))
              win_nxt = win_r | (48'(c) << {lcnt_r[2:0], 3'b000});
            lcnt_nxt = sadd(lcnt_r, 2'd1);
          end
          ST_INT: if (digit_byte(c)) begin
            fl = 1'b0;
            lcnt_nxt = sadd(lcnt_r, 2'd1);
          end else if (c == 8'h2e) begin
            fl = 1'b0;
            st_nxt = ST_INT_DOT;
          end
          ST_INT_DOT: if (digit_byte(c)) begin
            fl = 1'b0;
            lcnt_nxt = sadd(lcnt_r, 2'd2);
            st_nxt = ST_FRAC;
          end
          ST_FRAC: if (digit_byte(c)) begin
            fl = 1'b0;
            lcnt_nxt = sadd(lcnt_r, 2'd1);
          end
          ST_SLASH: if (c == 8'h2f) begin
            fl = 1'b0;
            st_nxt = ST_LINE_CMT;
          end else if (c == 8'h2a) begin
            fl = 1'b0;
            st_nxt = ST_BLOCK;
          end
          ST_OP2: if (pair_kind(pend_r, c) != 6'd0) begin
            fl = 1'b0;
            t[0] = '{pair_kind(pend_r, c), fsat(lstart_r), 16'd2, fsat(line_r), 1'b0};
            n = 2'd1;
            st_nxt = ST_IDLE;
          end
          ST_LINE_CMT: begin
            fl = 1'b0;
            if (c == 8'h0a) begin
              line_nxt = sadd(line_r, 2'd1);
              st_nxt = ST_IDLE;
            end
          end
          ST_BLOCK: begin
            fl = 1'b0;
            if (c == 8'h2a) st_nxt = ST_BLOCK_STAR;
            else if (c == 8'h0a) line_nxt = sadd(line_r, 2'd1);
          end
          ST_BLOCK_STAR: begin
            fl = 1'b0;
            if (c == 8'h2f) st_nxt = ST_IDLE;
            else if (c == 8'h0a) begin
              line_nxt = sadd(line_r, 2'd1);
              st_nxt = ST_BLOCK;
            end else if (c != 8'h2a) st_nxt = ST_BLOCK;
          end
          default: fl = 1'b1;
        endcase
      end

      if (fl) begin
        // flush pending token
        case (st_r)
          ST_IDENT: begin
            t[n] = '{ident_kind(win_r, wn), fsat(lstart_r), fsat(lcnt_r), fsat(line_r), 1'b0};
            n = n + 2'd1;
          end
          ST_INT: begin
            t[n] = '{K_INT, fsat(lstart_r), fsat(lcnt_r), fsat(line_r), 1'b0};
            n = n + 2'd1;
          end
          ST_INT_DOT: begin
            t[0] = '{K_INT, fsat(lstart_r), fsat(lcnt_r), fsat(line_r), 1'b0};
            t[1] = '{K_ERROR, fsat(sadd2(lstart_r, lcnt_r)), 16'd1, fsat(line_r), 1'b0};
            n = 2'd2;
          end
          ST_FRAC: begin
            t[n] = '{K_DOUBLE, fsat(lstart_r), fsat(lcnt_r), fsat(line_r), 1'b0};
            n = n + 2'd1;
          end
          ST_SLASH: begin
            t[n] = '{K_SLASH, fsat(lstart_r), 16'd1, fsat(line_r), 1'b0};
            n = n + 2'd1;
          end
          ST_OP2: begin
            t[n] = '{lone_kind(pend_r), fsat(lstart_r), 16'd1, fsat(line_r), 1'b0};
            n = n + 2'd1;
          end
          default: ;
        endcase
        st_nxt = ST_IDLE;

        if (c == 8'h00) begin
          t[n] = '{K_EOF, fsat(pos_r), 16'd0, fsat(line_r), 1'b0};
          n = n + 2'd1;
          ended_nxt = 1'b1;
        end else if (c == 8'h20 || c == 8'h0d || c == 8'h09) begin
        end else if (c == 8'h0a) begin
          line_nxt = sadd(line_r, 2'd1);
        end else begin
          lstart_nxt = pos_r;
          if (alpha_byte(c)) begin
            st_nxt = ST_IDENT;
            lcnt_nxt = OFFSET_BITS'(1);
            win_nxt = 48'(c);
          end else if (digit_byte(c)) begin
            st_nxt = ST_INT;
            lcnt_nxt = OFFSET_BITS'(1);
          end else if (c == 8'h2f) begin
            st_nxt = ST_SLASH;
            pend_nxt = c;
          end else if (c == 8'h26 || c == 8'h7c || c == 8'h21 || c == 8'h3d ||
                       c == 8'h3c || c == 8'h3e) begin
            st_nxt = ST_OP2;
            pend_nxt = c;
          end else begin
            k = lone_kind(c);
            t[n] = '{(k != 6'd0) ? k : K_ERROR, fsat(pos_r), 16'd1, fsat(line_r), 1'b0};
            n = n + 2'd1;
          end
        end
      end
      if (c != 8'h00) pos_nxt = sadd(pos_r, 2'd1);
      // token line follows the line at emission, which only changes after
      // every emit of this byte except newline cases with no token
    end

    if (n != 2'd0) t[n - 2'd1].last = 1'b1;
    b.count = n;
    b.tok0  = t[0];
    b.tok1  = t[1];
    b.tok2  = t[2];
  end

  assign q_valid = acc && (b.count != 2'd0);
  assign q_data  = b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      pos_r    <= '0;
      line_r   <= OFFSET_BITS'(1);
      lstart_r <= '0;
      lcnt_r   <= '0;
      win_r    <= '0;
      pend_r   <= '0;
      ended_r  <= 1'b0;
    end else if (acc) begin
      st_r     <= st_nxt;
      pos_r    <= pos_nxt;
      line_r   <= line_nxt;
      lstart_r <= lstart_nxt;
      lcnt_r   <= lcnt_nxt;
      win_r    <= win_nxt;
      pend_r   <= pend_nxt;
      ended_r  <= ended_nxt;
    end
  end
endmodule

FILE: rtl/stt_queue.sv
module stt_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  stt_pkg::burst_t wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output stt_pkg::burst_t rd_data
);
  import stt_pkg::*;

  burst_t     mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr       = wr_valid && wr_ready;
  assign rd       = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

FILE: rtl/stt_back.sv
module stt_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_ready,
  input  stt_pkg::burst_t q_data,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [5:0]      out_kind,
  output logic [15:0]     out_start_offset,
  output logic [15:0]     out_lexeme_length,
  output logic [15:0]     out_line_number,
  output logic            out_last
);
  import stt_pkg::*;

  logic [1:0] idx_r;
  token_t     tok;
  logic       beat;

  always_comb begin
    case (idx_r)
      2'd0:    tok = q_data.tok0;
      2'd1:    tok = q_data.tok1;
      default: tok = q_data.tok2;
    endcase
  end

  // walk the tokens of one burst, release the entry with its last beat
  assign beat      = q_valid && out_ready;
  assign out_valid = q_valid;
  assign q_ready   = beat && (idx_r + 2'd1 == q_data.count);

  assign out_kind          = tok.kind;
  assign out_start_offset  = tok.start_offset;
  assign out_lexeme_length = tok.lexeme_length;
  assign out_line_number   = tok.line_number;
  assign out_last          = tok.last;

  always_ff @(posedge clk) begin
    if (!rst_n) idx_r <= 2'd0;
    else if (q_ready) idx_r <= 2'd0;
    else if (beat) idx_r <= idx_r + 2'd1;
  end
endmodule

FILE: rtl/source_text_tokenizer.sv
// Tokens of an accepted byte are registered in a two-entry burst queue between
// scanner and token sequencer. Throughput: one byte per cycle while the queue
// is not full; a byte causing k tokens holds k output beats, absorbed there.
// Reset (rst_n low, synchronous): scanner idle, offset 0, line 1, queue empty.
module source_text_tokenizer #(
  parameter int OFFSET_BITS = stt_pkg::OffsetBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_ch,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_kind,
  output logic [15:0] out_start_offset,
  output logic [15:0] out_lexeme_length,
  output logic [15:0] out_line_number,
  output logic        out_last
);
  import stt_pkg::*;

  burst_t fq_data, qb_data;
  logic   fq_valid, fq_ready, qb_valid, qb_ready;

  stt_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_ch,
    .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
  );

  stt_queue u_queue (
    .clk, .rst_n,
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_data)
  );

  stt_back u_back (
    .clk, .rst_n,
    .q_valid(qb_valid), .q_ready(qb_ready), .q_data(qb_data),
    .out_valid, .out_ready, .out_kind, .out_start_offset,
    .out_lexeme_length, .out_line_number, .out_last
  );
endmodule
